FILE: design/r4t_pkg.sv
// ----------------------------------------------------------------------------
// r4t_pkg
// Types, codes and sizes shared by the quaternary radix trie index map.
// ----------------------------------------------------------------------------
package r4t_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int VALUE_COUNT = 1024;
    localparam int LEVEL_LIMIT = 32;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int VAL_W  = 10;
    localparam int FC_W   = $clog2(NODE_COUNT + 1);
    localparam int LVL_W  = 6;
    localparam int PATH_W = $clog2(LEVEL_LIMIT);

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_LOWER  = 3'd3,
        ACT_UPPER  = 3'd4
    } action_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_LEVELS    = 3'd3,
        ST_POOL      = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        CFG_LEVEL_COUNT = 2'd0,
        CFG_DESCENDING  = 2'd1,
        CFG_BASE_SHIFT  = 2'd2
    } cfg_index_e;

    localparam logic [1:0] KIND_EMPTY = 2'b00;
    localparam logic [1:0] KIND_LEAF  = 2'b01;
    localparam logic [1:0] KIND_NODE  = 2'b10;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] key;
        logic [9:0]  value;
    } cmd_t;

    typedef struct packed {
        logic       found;
        logic [9:0] result_value;
        logic [2:0] status;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [NODE_W-1:0] idx;
    } slot_t;

    typedef slot_t [3:0] row_t;

endpackage

FILE: design/radix4_trie_index_map_core.sv
// ----------------------------------------------------------------------------
// radix4_trie_index_map_core
// Quaternary radix trie mapping 64-bit keys to value indices, walked one node
// row per cycle, save for key checks and add push-downs, by a small sequencer.
// ----------------------------------------------------------------------------
// Sequence: an item reads the root row, then one more row per level walked; a leaf
//   adds a key check, each add push-down adds the pop, link and re-evaluation steps,
//   and a collapse adds the parent write. Worst case: an add pushing down through 32 levels.
// Throughput: one item at a time; busy drops in the result strobe cycle, so the
//   next item may be taken at the edge ending it. The node-row read port paces it.
// Reset: root row cleared, free pool count NODE_COUNT-1, at once; the receiver cannot stall.
module radix4_trie_index_map_core
    import r4t_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  cmd_t       cmd,
    output logic       done,
    output rsp_t       result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_KEY,
        S_APOP,
        S_ALINK,
        S_RCOL,
        S_BSCAN,
        S_DPICK
    } state_t;

    function automatic logic [1:0] digit_of(input logic [63:0] k, input logic [LVL_W-1:0] lvl,
                                            input logic desc, input logic [5:0] base);
        logic [7:0]  sh;
        logic [63:0] w;
        sh = desc ? ({2'b00, base} - {1'b0, lvl, 1'b0}) : ({2'b00, base} + {1'b0, lvl, 1'b0});
        w  = k >> sh[5:0];
        return (sh[7:6] != 2'b00) ? 2'b00 : w[1:0];
    endfunction

    function automatic rsp_t mk_rsp(input logic f, input logic [9:0] v, input status_e s);
        rsp_t r;
        r.found        = f;
        r.result_value = v;
        r.status       = s;
        return r;
    endfunction

    // Control state
    state_t            state_reg, state_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    logic [FC_W-1:0]   fc_reg, fc_next;
    logic [FC_W-1:0]   lw_reg, lw_next;
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;
    logic [NODE_W-1:0] rd_node_reg;
    row_t              root_reg;
    logic [5:0]        level_count_reg;
    logic              desc_reg;
    logic [5:0]        base_reg;

    // Working payload of the item in flight
    logic [2:0]        act_reg, act_next;
    logic [63:0]       key_reg, key_next;
    logic [9:0]        val_reg, val_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [NODE_W-1:0] parent_reg, parent_next;
    logic [1:0]        pdigit_reg, pdigit_next;
    row_t              row_reg, row_next;
    row_t              prow_reg, prow_next;
    logic [1:0]        d_reg, d_next;
    slot_t             e_reg, e_next;
    logic [63:0]       okey_reg, okey_next;
    slot_t             left_reg, left_next;
    logic [NODE_W-1:0] nn_reg, nn_next;

    logic [NODE_W-1:0] path_node_reg [LEVEL_LIMIT];
    logic [1:0]        path_digit_reg [LEVEL_LIMIT];

    // Memories
    row_t              node_mem [NODE_COUNT];
    logic [63:0]       vk_mem [VALUE_COUNT];
    logic [NODE_W-1:0] fn_mem [NODE_COUNT];
    row_t              node_q;
    logic [63:0]       vk_q;
    logic [NODE_W-1:0] fn_q;

    logic              nrd_en, nwr_en, vrd_en, vwr_en, frd_en, fwr_en, path_wr;
    logic [NODE_W-1:0] nrd_addr, nwr_addr, frd_addr;
    logic [9:0]        vrd_addr;
    row_t              nwr_data;

    logic              accept;
    logic [LVL_W-1:0]  lv_eff;
    logic              last_level;
    row_t              cur_row;
    logic [1:0]        dcur;
    slot_t             ecur;
    logic              upper;
    logic              sib_hit, pick_hit;
    logic [1:0]        sib_d, pick_d;
    row_t              cleared_row;
    logic [2:0]        left_count;
    slot_t             left_slot;
    logic [LVL_W-1:0]  level_m1;
    logic [FC_W-1:0]   fc_m1;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = rsp_reg;
    assign cfg_ready = 1'b1;

    // Clamp the level count to 1..LEVEL_LIMIT
    assign lv_eff = (level_count_reg == '0) ? LVL_W'(1) :
                    (level_count_reg > LVL_W'(LEVEL_LIMIT)) ? LVL_W'(LEVEL_LIMIT) : level_count_reg;
    assign last_level = ({1'b0, level_reg} + 7'd1) >= {1'b0, lv_eff};

    // The root row lives in flip-flops; every other row comes from the memory
    assign cur_row  = (rd_node_reg == '0) ? root_reg : node_q;
    assign dcur     = digit_of(key_reg, level_reg, desc_reg, base_reg);
    assign ecur     = cur_row[dcur];
    assign upper    = (act_reg == ACT_UPPER);
    assign level_m1 = level_reg - LVL_W'(1);
    assign fc_m1    = fc_reg - FC_W'(1);

    // Nearest occupied sibling beyond the taken digit, and first occupied slot in walk order
    always_comb
    begin
        logic [1:0] j;
        sib_hit  = 1'b0;
        sib_d    = d_reg;
        pick_hit = 1'b0;
        pick_d   = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            j = upper ? 2'(i) : 2'(3 - i);
            if (!sib_hit && cur_row[j].kind != KIND_EMPTY && (upper ? (j > d_reg) : (j < d_reg)))
            begin
                sib_hit = 1'b1;
                sib_d   = j;
            end
            if (!pick_hit && cur_row[j].kind != KIND_EMPTY)
            begin
                pick_hit = 1'b1;
                pick_d   = j;
            end
        end
    end

    // Row after the removed leaf is cleared, with its occupancy
    always_comb
    begin
        cleared_row        = row_reg;
        cleared_row[d_reg] = '0;
        left_count         = 3'd0;
        left_slot          = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cleared_row[i].kind != KIND_EMPTY)
            begin
                left_count = left_count + 3'd1;
                left_slot  = cleared_row[i];
            end
        end
    end

    always_comb
    begin
        slot_t      de;
        logic       dgo;
        logic [1:0] od;
        state_next  = state_reg;
        level_next  = level_reg;
        fc_next     = fc_reg;
        lw_next     = lw_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        act_next    = act_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        node_next   = node_reg;
        parent_next = parent_reg;
        pdigit_next = pdigit_reg;
        row_next    = row_reg;
        prow_next   = prow_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        okey_next   = okey_reg;
        left_next   = left_reg;
        nn_next     = nn_reg;
        nrd_en      = 1'b0;
        nrd_addr    = node_reg;
        nwr_en      = 1'b0;
        nwr_addr    = node_reg;
        nwr_data    = row_reg;
        vrd_en      = 1'b0;
        vrd_addr    = ecur.idx;
        vwr_en      = 1'b0;
        frd_en      = 1'b0;
        frd_addr    = fc_m1[NODE_W-1:0];
        fwr_en      = 1'b0;
        path_wr     = 1'b0;
        de          = (state_reg == S_DPICK) ? cur_row[pick_d] : cur_row[sib_d];
        dgo         = (state_reg == S_DPICK) ? pick_hit : sib_hit;
        od          = digit_of(okey_reg, level_reg + LVL_W'(1), desc_reg, base_reg);

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = cmd.action;
                    key_next   = cmd.key;
                    val_next   = cmd.value;
                    level_next = '0;
                    node_next  = '0;
                    if (cmd.action > ACT_UPPER)
                    begin
                        rsp_next  = mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                        done_next = 1'b1;
                    end
                    else
                    begin
                        nrd_en     = 1'b1;
                        nrd_addr   = '0;
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                row_next = cur_row;
                d_next   = dcur;
                e_next   = ecur;
                if (act_reg == ACT_LOWER || act_reg == ACT_UPPER)
                begin
                    path_wr = 1'b1;
                end
                case (ecur.kind)
                    KIND_EMPTY:
                    begin
                        if (act_reg == ACT_ADD)
                        begin
                            vwr_en         = 1'b1;
                            nwr_en         = 1'b1;
                            nwr_data       = cur_row;
                            nwr_data[dcur] = {KIND_LEAF, val_reg};
                            rsp_next       = mk_rsp(1'b1, val_reg, ST_OK);
                            done_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else if (act_reg == ACT_LOWER || act_reg == ACT_UPPER)
                        begin
                            state_next = S_BSCAN;
                        end
                        else
                        begin
                            rsp_next   = mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_LEAF:
                    begin
                        vrd_en     = 1'b1;
                        state_next = S_KEY;
                    end
                    default:
                    begin
                        // Link to a deeper node: advance unless the levels run out
                        if (last_level)
                        begin
                            rsp_next   = mk_rsp(1'b0, 10'd0,
                                                (act_reg == ACT_ADD) ? ST_LEVELS : ST_NOT_FOUND);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            prow_next   = cur_row;
                            parent_next = node_reg;
                            pdigit_next = dcur;
                            nrd_en      = 1'b1;
                            nrd_addr    = ecur.idx;
                            node_next   = ecur.idx;
                            level_next  = level_reg + LVL_W'(1);
                        end
                    end
                endcase
            end

            S_KEY:
            begin
                case (act_reg)
                    ACT_ADD:
                    begin
                        if (vk_q == key_reg)
                        begin
                            rsp_next   = mk_rsp(1'b0, e_reg.idx, ST_DUPLICATE);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (last_level)
                        begin
                            rsp_next   = mk_rsp(1'b0, 10'd0, ST_LEVELS);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (fc_reg == '0)
                        begin
                            rsp_next   = mk_rsp(1'b0, 10'd0, ST_POOL);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            frd_en     = 1'b1;
                            fc_next    = fc_m1;
                            okey_next  = vk_q;
                            state_next = S_APOP;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (vk_q != key_reg)
                        begin
                            rsp_next   = mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            nwr_en    = 1'b1;
                            nwr_data  = cleared_row;
                            left_next = left_slot;
                            if (left_count == 3'd1 && left_slot.kind == KIND_LEAF
                                && level_reg != '0)
                            begin
                                state_next = S_RCOL;
                            end
                            else
                            begin
                                rsp_next   = mk_rsp(1'b1, e_reg.idx, ST_OK);
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                    end
                    ACT_FIND:
                    begin
                        rsp_next   = (vk_q == key_reg) ? mk_rsp(1'b1, e_reg.idx, ST_OK)
                                                       : mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        if (upper ? (vk_q >= key_reg) : (vk_q <= key_reg))
                        begin
                            rsp_next   = mk_rsp(1'b1, e_reg.idx, ST_OK);
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_BSCAN;
                        end
                    end
                endcase
            end

            S_APOP:
            begin
                // Entries below the low-water mark are unwritten; their node is the index plus one
                if (fc_reg < lw_reg)
                begin
                    nn_next = fc_reg[NODE_W-1:0] + NODE_W'(1);
                    lw_next = fc_reg;
                end
                else
                begin
                    nn_next = fn_q;
                end
                nwr_en       = 1'b1;
                nwr_addr     = nn_next;
                nwr_data     = '0;
                nwr_data[od] = e_reg;
                state_next   = S_ALINK;
            end

            S_ALINK:
            begin
                nwr_en          = 1'b1;
                nwr_data        = row_reg;
                nwr_data[d_reg] = {KIND_NODE, nn_reg};
                nrd_en          = 1'b1;
                nrd_addr        = nn_reg;
                node_next       = nn_reg;
                level_next      = level_reg + LVL_W'(1);
                state_next      = S_EVAL;
            end

            S_RCOL:
            begin
                nwr_en               = 1'b1;
                nwr_addr             = parent_reg;
                nwr_data             = prow_reg;
                nwr_data[pdigit_reg] = left_reg;
                if (fc_reg < FC_W'(NODE_COUNT))
                begin
                    fwr_en  = 1'b1;
                    fc_next = fc_reg + FC_W'(1);
                end
                rsp_next   = mk_rsp(1'b1, e_reg.idx, ST_OK);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_BSCAN, S_DPICK:
            begin
                if (dgo)
                begin
                    if (de.kind == KIND_LEAF)
                    begin
                        rsp_next   = mk_rsp(1'b1, de.idx, ST_OK);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (de.kind == KIND_EMPTY || last_level)
                    begin
                        rsp_next   = mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        nrd_en     = 1'b1;
                        nrd_addr   = de.idx;
                        node_next  = de.idx;
                        level_next = level_reg + LVL_W'(1);
                        state_next = S_DPICK;
                    end
                end
                else if (state_reg == S_BSCAN && level_reg != '0)
                begin
                    // Back up one level and rescan that node's siblings
                    nrd_en     = 1'b1;
                    nrd_addr   = path_node_reg[level_m1[PATH_W-1:0]];
                    node_next  = path_node_reg[level_m1[PATH_W-1:0]];
                    d_next     = path_digit_reg[level_m1[PATH_W-1:0]];
                    level_next = level_m1;
                end
                else
                begin
                    rsp_next   = mk_rsp(1'b0, 10'd0, ST_NOT_FOUND);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            level_reg       <= '0;
            fc_reg          <= FC_W'(NODE_COUNT - 1);
            lw_reg          <= FC_W'(NODE_COUNT - 1);
            done_reg        <= 1'b0;
            rsp_reg         <= '0;
            rd_node_reg     <= '0;
            root_reg        <= '0;
            level_count_reg <= 6'd32;
            desc_reg        <= 1'b0;
            base_reg        <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            fc_reg    <= fc_next;
            lw_reg    <= lw_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
            if (nrd_en)
            begin
                rd_node_reg <= nrd_addr;
            end
            if (nwr_en && nwr_addr == '0)
            begin
                root_reg <= nwr_data;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LEVEL_COUNT: level_count_reg <= cfg_data;
                    CFG_DESCENDING:  desc_reg        <= cfg_data[0];
                    CFG_BASE_SHIFT:  base_reg        <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        node_reg   <= node_next;
        parent_reg <= parent_next;
        pdigit_reg <= pdigit_next;
        row_reg    <= row_next;
        prow_reg   <= prow_next;
        d_reg      <= d_next;
        e_reg      <= e_next;
        okey_reg   <= okey_next;
        left_reg   <= left_next;
        nn_reg     <= nn_next;
        if (path_wr)
        begin
            path_node_reg[level_reg[PATH_W-1:0]]  <= node_reg;
            path_digit_reg[level_reg[PATH_W-1:0]] <= dcur;
        end
    end

    // Node rows: the root row is held apart in flip-flops
    always_ff @(posedge clk)
    begin
        if (nwr_en && nwr_addr != '0)
        begin
            node_mem[nwr_addr] <= nwr_data;
        end
        if (nrd_en)
        begin
            node_q <= node_mem[nrd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            vk_mem[val_reg] <= key_reg;
        end
        if (vrd_en)
        begin
            vk_q <= vk_mem[vrd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwr_en)
        begin
            fn_mem[fc_reg[NODE_W-1:0]] <= node_reg;
        end
        if (frd_en)
        begin
            fn_q <= fn_mem[frd_addr];
        end
    end

    // A result reports success exactly when its status is ok
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.found == (result.status == ST_OK)))
        else $error("found and status disagree");

    // The strobe always comes with the sequencer back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A valid action always occupies the sequencer
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.action <= ACT_UPPER) |=> busy)
        else $error("accepted item did not start");

    // The free pool never holds more than every node number
    a_pool: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FC_W'(NODE_COUNT))
        else $error("free pool overflow");

endmodule
